// ===== design/tcap_pkg.sv =====
// tachometer package: state encoding, register codes, widths and reset values
// shared by the divider and the top level; depends on nothing
`timescale 1ns / 1ps

package tcap_pkg;

    localparam int DIVIDEND_W = 28;
    localparam int DIVISOR_W  = 16;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

    localparam logic       OP_CAPTURE = 1'b0;
    localparam logic       OP_TICK    = 1'b1;

    localparam logic       REG_RPM    = 1'b0;
    localparam logic       REG_STOP   = 1'b1;

    localparam logic [23:0] RPM_RESET  = 24'd300000;
    localparam logic [7:0]  STOP_RESET = 8'd20;
    localparam logic [7:0]  TICKS_MAX  = 8'hFF;
    localparam logic [27:0] SPEED_MAX  = 28'h0FFFFFFF;
    localparam logic [15:0] WRAP_ADD   = 16'hFFFF;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PUT,
        S_TICK
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== design/multi_channel_capture_tachometer.sv =====
// capture item: the divider runs, the sequencer sees its done flag, then loads the result
//   register and returns to idle, where the next beat is taken; a held result stalls the load
// zero period skips the divider: the sequencer goes straight to loading the result register
// a tick loads one timed-out beat per timed-out channel, lowest first, and none when none times out
// synchronous active-low reset restores the register defaults and clears captures and counts
`timescale 1ns / 1ps

module multi_channel_capture_tachometer #(
    parameter int CHANNELS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // capture and tick items
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [1:0]  i_channel,
    input  logic [15:0] i_capture_value,
    // speed results
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_out_channel,
    output logic [27:0] o_speed,
    output logic        o_zero_period,
    output logic        o_timed_out,
    output logic        o_last,
    // register port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import tcap_pkg::*;

    // the channel field reaches four channels at most
    localparam int         NCH    = (CHANNELS < 4) ? CHANNELS : 4;
    localparam int         CHW    = (NCH > 1) ? $clog2(NCH) : 1;
    localparam logic [2:0] NCH_L  = 3'(NCH);

    t_state              r_state, n_state;
    logic [23:0]         r_rpm;
    logic [7:0]          r_stop;
    logic [15:0]         r_prev [0:NCH-1];
    logic [7:0]          r_idle [0:NCH-1];
    logic [1:0]          r_ch;
    logic                r_zp;
    logic [NCH-1:0]      r_mask, n_mask;

    logic                r_out_valid;
    logic [1:0]          r_out_channel;
    logic [27:0]         r_speed;
    logic                r_zero_period;
    logic                r_timed_out;
    logic                r_last;

    logic                w_in_acc;
    logic                w_cap;
    logic                w_tick;
    logic                w_ch_ok;
    logic [CHW-1:0]      w_idx;
    logic [15:0]         w_old;
    logic [16:0]         w_per_wide;
    logic [15:0]         w_period;
    logic                w_div_start;
    logic [7:0]          w_inc [0:NCH-1];
    logic [NCH-1:0]      w_hit;
    logic [NCH-1:0]      w_low;
    logic [1:0]          w_sel;
    logic                w_out_free;
    logic                w_load;
    logic [1:0]          w_ld_ch;
    logic [27:0]         w_ld_speed;
    logic                w_ld_zp;
    logic                w_ld_to;
    logic                w_ld_last;
    logic                w_cfg_wr;

    t_div_stat           w_div_stat;
    logic [27:0]         w_quotient;

    // ---------------- register port ----------------
    assign w_cfg_wr = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == REG_STOP) ? {24'b0, r_stop} : {8'b0, r_rpm};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpm  <= RPM_RESET;
            r_stop <= STOP_RESET;
        end else if (w_cfg_wr) begin
            if (i_paddr[2] == REG_RPM) begin
                r_rpm <= i_pwdata[23:0];
            end else begin
                r_stop <= i_pwdata[7:0];
            end
        end
    end

    // ---------------- input decode ----------------
    assign o_ready  = (r_state == S_IDLE);
    assign w_in_acc = i_valid && o_ready;
    assign w_ch_ok  = ({1'b0, i_channel} < NCH_L);
    assign w_cap    = w_in_acc && (i_opcode == OP_CAPTURE) && w_ch_ok;
    assign w_tick   = w_in_acc && (i_opcode == OP_TICK);
    assign w_idx    = i_channel[CHW-1:0];
    assign w_old    = r_prev[w_idx];

    // wrap rule: new plus 0xFFFF minus old when the timer has not moved forward
    assign w_per_wide = (i_capture_value > w_old)
                      ? ({1'b0, i_capture_value} - {1'b0, w_old})
                      : ({1'b0, i_capture_value} + {1'b0, WRAP_ADD - w_old});
    assign w_period    = w_per_wide[15:0];
    assign w_div_start = w_cap && (w_period != '0);

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            w_inc[c] = (r_idle[c] == TICKS_MAX) ? TICKS_MAX : r_idle[c] + 8'd1;
            w_hit[c] = (w_inc[c] >= r_stop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NCH; c++) begin
                r_prev[c] <= '0;
                r_idle[c] <= '0;
            end
        end else if (w_cap) begin
            r_prev[w_idx] <= i_capture_value;
            r_idle[w_idx] <= '0;
        end else if (w_tick) begin
            for (int c = 0; c < NCH; c++) begin
                r_idle[c] <= w_hit[c] ? 8'd0 : w_inc[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cap) begin
            r_ch <= i_channel;
            r_zp <= (w_period == '0);
        end
    end

    // ---------------- shared divider ----------------
    tcap_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({r_rpm, 4'b0000}),
        .i_divisor  (w_period),
        .o_stat     (w_div_stat),
        .o_quotient (w_quotient)
    );

    // ---------------- sequencer ----------------
    // lowest pending timed-out channel goes first
    assign w_low = r_mask & (~r_mask + 1'b1);

    always_comb begin
        w_sel = '0;
        for (int c = NCH - 1; c >= 0; c--) begin
            if (r_mask[c]) begin
                w_sel = 2'(c);
            end
        end
    end

    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state    = r_state;
        n_mask     = r_mask;
        w_load     = 1'b0;
        w_ld_ch    = r_ch;
        w_ld_speed = r_zp ? SPEED_MAX : w_quotient;
        w_ld_zp    = r_zp;
        w_ld_to    = 1'b0;
        w_ld_last  = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (w_cap) begin
                    n_state = (w_period == '0) ? S_PUT : S_DIV;
                end else if (w_tick) begin
                    n_mask  = w_hit;
                    n_state = S_TICK;
                end
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_TICK: begin
                w_ld_ch    = w_sel;
                w_ld_speed = '0;
                w_ld_zp    = 1'b0;
                w_ld_to    = 1'b1;
                w_ld_last  = ((r_mask & ~w_low) == '0);
                if (r_mask == '0) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    w_load = 1'b1;
                    n_mask = r_mask & ~w_low;
                    if (w_ld_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mask  <= '0;
        end else begin
            r_state <= n_state;
            r_mask  <= n_mask;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_channel <= w_ld_ch;
            r_speed       <= w_ld_speed;
            r_zero_period <= w_ld_zp;
            r_timed_out   <= w_ld_to;
            r_last        <= w_ld_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_channel = r_out_channel;
    assign o_speed       = r_speed;
    assign o_zero_period = r_zero_period;
    assign o_timed_out   = r_timed_out;
    assign o_last        = r_last;

    // ---------------- checks ----------------
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_zero_period && o_timed_out))
        else $error("zero period and timeout flagged on one beat");

    a_timeout_speed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_timed_out) |-> (o_speed == '0))
        else $error("timed-out beat with nonzero speed");

    a_capture_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_timed_out) |-> o_last)
        else $error("capture beat not marked last");

    a_div_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (w_div_stat.busy || w_div_stat.done))
        else $error("waiting on an idle divider");

    a_no_load_over_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> !$past(w_load))
        else $error("result register overwritten before the beat was taken");

endmodule

// ===== design/tcap_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on tcap_pkg for the operand widths and the status struct
`timescale 1ns / 1ps

module tcap_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [tcap_pkg::DIVIDEND_W-1:0]     i_dividend,
    input  logic [tcap_pkg::DIVISOR_W-1:0]      i_divisor,
    output tcap_pkg::t_div_stat                 o_stat,
    output logic [tcap_pkg::DIVIDEND_W-1:0]     o_quotient
);
    import tcap_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dsr;
    logic [DIVIDEND_W-1:0] r_quo;

    logic [DIVISOR_W:0]    w_trial;
    logic [DIVISOR_W+1:0]  w_diff;
    logic                  w_fits;

    // shift the next dividend bit into the partial remainder and try the subtract
    assign w_trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_dsr};
    assign w_fits  = !w_diff[DIVISOR_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIVIDEND_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits the divisor width
            r_rem <= w_fits ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_fits};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule
